// File: design/ttg_pkg.sv
`default_nettype none
package ttg_pkg;

  localparam int EdgeW    = 33;
  localparam int DeltaW   = 17;
  localparam int ProdW    = 50;
  localparam int DetW     = 35;
  localparam int NumW     = 51;
  localparam int MagW     = 50;
  localparam int QuoW     = 32;
  localparam int FracBits = 14;
  localparam int PreShift = QuoW - FracBits;
  localparam int FifoDepth = 2;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int DivCntW   = $clog2(QuoW);

  localparam logic [1:0] LastCorner = 2'd2;
  localparam logic [1:0] LastComp   = 2'd2;

  typedef struct packed {
    logic [31:0]        vertex_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        out_vertex_id;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic               degenerate;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [2:0][31:0]       vid;
    logic [2:0][EdgeW-1:0]  e1;
    logic [2:0][EdgeW-1:0]  e2;
    logic [DeltaW-1:0]      d1u;
    logic [DeltaW-1:0]      d1v;
    logic [DeltaW-1:0]      d2u;
    logic [DeltaW-1:0]      d2v;
  } job_t;

  typedef struct packed {
    logic            start;
    logic [MagW-1:0] num;
    logic [DetW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [QuoW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkDetMul,
    BkDetSub,
    BkNumMul,
    BkNumSub,
    BkDiv,
    BkEmit
  } back_state_e;

endpackage
`default_nettype wire

// File: design/ttg_front.sv
`default_nettype none
module ttg_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ttg_pkg::in_word_t in_word_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output ttg_pkg::job_t          job_o
);
  import ttg_pkg::*;

  logic [1:0]       cnt_q, cnt_d;
  logic [2:0][31:0] c0_pos_q, c1_pos_q;
  logic [15:0]      c0_u_q, c0_v_q, c1_u_q, c1_v_q;
  logic [31:0]      c0_id_q, c1_id_q;
  logic [2:0][31:0] cur_pos;
  logic             acc;

  assign cur_pos    = {in_word_i.pos_z, in_word_i.pos_y, in_word_i.pos_x};
  assign in_stall_o = (cnt_q == LastCorner) && full_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign push_o     = acc && (cnt_q == LastCorner);
  assign cnt_d      = (cnt_q == LastCorner) ? 2'd0 : cnt_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (acc) begin
      cnt_q <= cnt_d;
    end
  end

  // corner storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (acc && cnt_q == 2'd0) begin
      c0_pos_q <= cur_pos;
      c0_u_q   <= in_word_i.tex_u;
      c0_v_q   <= in_word_i.tex_v;
      c0_id_q  <= in_word_i.vertex_id;
    end
    if (acc && cnt_q == 2'd1) begin
      c1_pos_q <= cur_pos;
      c1_u_q   <= in_word_i.tex_u;
      c1_v_q   <= in_word_i.tex_v;
      c1_id_q  <= in_word_i.vertex_id;
    end
  end

  always_comb begin
    job_o.vid = {in_word_i.vertex_id, c1_id_q, c0_id_q};
    for (int j = 0; j < 3; j++) begin
      job_o.e1[j] = {c1_pos_q[j][31], c1_pos_q[j]} - {c0_pos_q[j][31], c0_pos_q[j]};
      job_o.e2[j] = {cur_pos[j][31], cur_pos[j]} - {c0_pos_q[j][31], c0_pos_q[j]};
    end
    job_o.d1u = {c1_u_q[15], c1_u_q} - {c0_u_q[15], c0_u_q};
    job_o.d1v = {c1_v_q[15], c1_v_q} - {c0_v_q[15], c0_v_q};
    job_o.d2u = {in_word_i.tex_u[15], in_word_i.tex_u} - {c0_u_q[15], c0_u_q};
    job_o.d2v = {in_word_i.tex_v[15], in_word_i.tex_v} - {c0_v_q[15], c0_v_q};
  end

endmodule
`default_nettype wire

// File: design/ttg_fifo.sv
`default_nettype none
module ttg_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ttg_pkg::job_t  data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output ttg_pkg::job_t       data_o
);
  import ttg_pkg::*;

  job_t               mem_q [FifoDepth];
  logic [FifoAw-1:0]  wr_q, rd_q;
  logic [FifoAw:0]    cnt_q;

  assign full_o  = (cnt_q == FifoAw'(0) + (FifoAw+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + FifoAw'(1);
      if (pop_i)  rd_q <= rd_q + FifoAw'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (FifoAw+1)'(1);
        2'b01:   cnt_q <= cnt_q - (FifoAw+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule
`default_nettype wire

// File: design/ttg_div.sv
`default_nettype none
module ttg_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ttg_pkg::div_req_t req_i,
  output ttg_pkg::div_rsp_t      rsp_o
);
  import ttg_pkg::*;

  logic              busy_q, done_q, ovf_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DetW-1:0]   den_q;
  logic [DetW-1:0]   rem_q;
  logic [QuoW-1:0]   low_q, quo_q;
  logic [DetW:0]     trial;
  logic              fits;

  // shift in one dividend bit, restoring subtract
  assign trial = {rem_q, low_q[QuoW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(QuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      // quotient of 32 bits overflows when num >> 18 reaches den
      ovf_q <= {{(DetW+PreShift-MagW){1'b0}}, req_i.num[MagW-1:PreShift]} >= req_i.den;
      rem_q <= {{(DetW+PreShift-MagW){1'b0}}, req_i.num[MagW-1:PreShift]};
      low_q <= {req_i.num[PreShift-1:0], {FracBits{1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DetW'(trial - {1'b0, den_q}) : trial[DetW-1:0];
      low_q <= {low_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quo  = quo_q;

endmodule
`default_nettype wire

// File: design/ttg_back.sv
`default_nettype none
module ttg_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire ttg_pkg::job_t      job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ttg_pkg::out_word_t      out_word_o
);
  import ttg_pkg::*;

  back_state_e        state_q, state_d;
  job_t               job_q;
  logic [1:0]         comp_q;
  logic signed [ProdW-1:0] pa_q, pb_q;
  logic signed [DetW-1:0]  det_q;
  logic               det_zero;
  logic               neg_q;
  logic [2:0][31:0]   tan_q;
  logic               out_valid_q;
  out_word_t          out_word_q;
  logic               out_load;
  logic signed [NumW-1:0]  num;
  logic [MagW-1:0]    num_mag;
  logic [DetW-1:0]    det_mag;
  logic               skip_div;
  logic [31:0]        sat;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign det_zero = (det_q == '0);
  assign num      = NumW'(pa_q) - NumW'(pb_q);
  assign num_mag  = num[NumW-1] ? MagW'(-num) : MagW'(num);
  assign det_mag  = det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);
  assign skip_div = det_zero;

  ttg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    if (div_rsp.ovf || div_rsp.quo[QuoW-1]) begin
      sat = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat = neg_q ? -div_rsp.quo : div_rsp.quo;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle:   if (!empty_i) state_d = BkDetMul;
      BkDetMul: state_d = BkDetSub;
      BkDetSub: state_d = BkNumMul;
      BkNumMul: state_d = BkNumSub;
      BkNumSub: begin
        if (!skip_div)                state_d = BkDiv;
        else if (comp_q == LastComp)  state_d = BkEmit;
        else                          state_d = BkNumMul;
      end
      BkDiv: begin
        if (div_rsp.done) state_d = (comp_q == LastComp) ? BkEmit : BkNumMul;
      end
      BkEmit: if (out_load && comp_q == LastComp) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  // control strobes
  always_comb begin
    pop_o         = (state_q == BkIdle) && !empty_i;
    div_req.start = (state_q == BkNumSub) && !skip_div;
    div_req.num   = num_mag;
    div_req.den   = det_mag;
    out_load      = (state_q == BkEmit) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      comp_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      priority if (state_q == BkDetSub) begin
        comp_q <= 2'd0;
      end else if ((state_q == BkNumSub && skip_div) || (state_q == BkDiv && div_rsp.done)) begin
        comp_q <= (comp_q == LastComp) ? 2'd0 : comp_q + 2'd1;
      end else if (out_load) begin
        comp_q <= (comp_q == LastComp) ? 2'd0 : comp_q + 2'd1;
      end else begin
        comp_q <= comp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    unique case (state_q)
      BkDetMul: begin
        pa_q <= ProdW'($signed(job_q.d1u) * $signed(job_q.d2v));
        pb_q <= ProdW'($signed(job_q.d1v) * $signed(job_q.d2u));
      end
      BkDetSub: det_q <= DetW'(pa_q - pb_q);
      BkNumMul: begin
        pa_q <= ProdW'($signed(job_q.e1[comp_q]) * $signed(job_q.d2v));
        pb_q <= ProdW'($signed(job_q.e2[comp_q]) * $signed(job_q.d1v));
      end
      BkNumSub: begin
        neg_q <= num[NumW-1] ^ det_q[DetW-1];
        if (skip_div) tan_q[comp_q] <= '0;
      end
      BkDiv: if (div_rsp.done) tan_q[comp_q] <= sat;
      default: ;
    endcase
    if (out_load) begin
      out_word_q.out_vertex_id <= job_q.vid[comp_q];
      out_word_q.tangent_x     <= tan_q[0];
      out_word_q.tangent_y     <= tan_q[1];
      out_word_q.tangent_z     <= tan_q[2];
      out_word_q.degenerate    <= det_zero;
      out_word_q.last          <= (comp_q == LastComp);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

// File: design/triangle_tangent_generator.sv
// channel | valid       | stall        | word
// corner  | in_valid_i  | in_stall_o   | in_word_i  (vertex id, position, uv)
// result  | out_valid_o | out_stall_i  | out_word_o (vertex id, tangent, flags)
// the first two corners of a triangle are taken one per cycle and only stored
// the third corner is taken and queued (two triangles deep);
// it stalls only while that queue is full
// per triangle: the bit-serial divider runs once per tangent component
// (32 steps per component), then three results one per cycle unless out_stall_i holds them
// a zero determinant skips the divider and gives zero components, then the results
// reset clears the corner count, the queue and the sequencer; no clearing pass
`default_nettype none
module triangle_tangent_generator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ttg_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ttg_pkg::out_word_t      out_word_o
);
  import ttg_pkg::*;

  // front to queue
  logic push, full;
  job_t job_in;
  // queue to back
  logic pop, empty;
  job_t job_out;

  // front: stores corners one and two, forms edges and uv deltas on the third
  ttg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  // short queue decouples corner intake from the long divide
  ttg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (job_out)
  );

  // back: determinant, numerators, divide with saturation, three results
  ttg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

// File: tb/sv/tangent_checker.sv
`timescale 1ns / 1ps
module tangent_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire ttg_pkg::in_word_t  in_word_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire ttg_pkg::out_word_t out_word_i,
  output int                      errors_o,
  output int                      pending_o,
  output int                      results_o,
  output int                      degenerate_seen_o,
  output int                      saturated_seen_o
);
  import ttg_pkg::*;

  out_word_t tangent_q[$];
  int        mismatches;

  // predictor state
  logic [1:0]         corners;
  logic signed [31:0] held_pos [2][3];
  logic signed [15:0] held_uv  [2][2];
  logic [31:0]        held_id  [2];

  function automatic logic [31:0] scaled_div(longint num, longint det);
    longint unsigned n, d, q1, r, q;
    logic neg;
    n   = (num < 0) ? -num : num;
    d   = (det < 0) ? -det : det;
    neg = (num < 0) != (det < 0);
    q1  = n / d;
    r   = n % d;
    if (q1 >= (64'd1 << 18)) q = 64'd1 << 32;
    else q = (q1 << 14) + ((r << 14) / d);
    if (neg) begin
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return 32'(q);
  endfunction

  task automatic take_corner(input in_word_t w);
    logic signed [31:0] p [3];
    longint e1, e2, d1u, d1v, d2u, d2v, det;
    logic [31:0] t [3];
    out_word_t r;
    p[0] = w.pos_x; p[1] = w.pos_y; p[2] = w.pos_z;
    if (corners < LastCorner) begin
      for (int j = 0; j < 3; j++) held_pos[corners[0]][j] = p[j];
      held_uv[corners[0]][0] = w.tex_u;
      held_uv[corners[0]][1] = w.tex_v;
      held_id[corners[0]] = w.vertex_id;
      corners = corners + 2'd1;
      return;
    end
    corners = 2'd0;
    d1u = longint'(held_uv[1][0]) - longint'(held_uv[0][0]);
    d1v = longint'(held_uv[1][1]) - longint'(held_uv[0][1]);
    d2u = longint'($signed(w.tex_u)) - longint'(held_uv[0][0]);
    d2v = longint'($signed(w.tex_v)) - longint'(held_uv[0][1]);
    det = d1u * d2v - d1v * d2u;
    for (int j = 0; j < 3; j++) begin
      e1 = longint'(held_pos[1][j]) - longint'(held_pos[0][j]);
      e2 = longint'(p[j]) - longint'(held_pos[0][j]);
      t[j] = (det == 0) ? 32'd0 : scaled_div(e1 * d2v - e2 * d1v, det);
      if (t[j] == 32'h7FFF_FFFF || t[j] == 32'h8000_0000) saturated_seen_o++;
    end
    if (det == 0) degenerate_seen_o++;
    for (int k = 0; k < 3; k++) begin
      r.out_vertex_id = (k == 2) ? w.vertex_id : held_id[k];
      r.tangent_x  = t[0];
      r.tangent_y  = t[1];
      r.tangent_z  = t[2];
      r.degenerate = (det == 0);
      r.last       = (k == 2);
      tangent_q = {tangent_q, r};
    end
  endtask

  task automatic flag(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h actual %h at %0t", what, exp_v, act_v, $realtime);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      corners = 2'd0;
      tangent_q.delete();
      mismatches = 0;
      results_o = 0;
      degenerate_seen_o = 0;
      saturated_seen_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (tangent_q.size() == 0) begin
          flag("unexpected word", 32'd0, out_word_i.out_vertex_id);
        end else begin
          e = tangent_q.pop_front();
          if (e.out_vertex_id !== out_word_i.out_vertex_id)
            flag("vertex id", e.out_vertex_id, out_word_i.out_vertex_id);
          if (e.tangent_x !== out_word_i.tangent_x)
            flag("tangent x", e.tangent_x, out_word_i.tangent_x);
          if (e.tangent_y !== out_word_i.tangent_y)
            flag("tangent y", e.tangent_y, out_word_i.tangent_y);
          if (e.tangent_z !== out_word_i.tangent_z)
            flag("tangent z", e.tangent_z, out_word_i.tangent_z);
          if (e.degenerate !== out_word_i.degenerate)
            flag("degenerate", e.degenerate, out_word_i.degenerate);
          if (e.last !== out_word_i.last)
            flag("last", e.last, out_word_i.last);
        end
      end
      if (in_valid_i && !in_stall_i) take_corner(in_word_i);
    end
    errors_o  = mismatches;
    pending_o = tangent_q.size();
  end
endmodule

// File: tb/sv/tb_triangle_tangent_generator.sv
`timescale 1ns / 1ps
module tb_triangle_tangent_generator;
  import ttg_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int errors, pending, results, degen_cnt, sat_cnt;
  int corners_sent;
  bit stall_mode;

  triangle_tangent_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // predicts tangents from the accepted corners and compares every result word
  tangent_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_word_i        (in_word),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_word_i       (out_word),
    .errors_o         (errors),
    .pending_o        (pending),
    .results_o        (results),
    .degenerate_seen_o(degen_cnt),
    .saturated_seen_o (sat_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side back-pressure: stretches of random stalls and stretches with none
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_mode <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
    end
  end

  // present one corner word and hold it until accepted
  task automatic send_corner(input in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    corners_sent++;
  endtask

  // drop valid for a random gap, sometimes none at all
  task automatic gap_after_burst(inout int burst_left);
    int gap;
    burst_left--;
    if (burst_left > 0) return;
    burst_left = $urandom_range(1, 12);
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
    if (gap == 0) return;
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  function automatic in_word_t corner(input logic [31:0] id, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z,
                                      input logic [15:0] u, input logic [15:0] v);
    in_word_t w;
    w.vertex_id = id;
    w.pos_x = x; w.pos_y = y; w.pos_z = z;
    w.tex_u = u; w.tex_v = v;
    return w;
  endfunction

  // random corner: mostly modest geometry, sometimes full-range fields
  function automatic in_word_t rand_corner();
    in_word_t w;
    w.vertex_id = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      w.pos_x = $urandom; w.pos_y = $urandom; w.pos_z = $urandom;
      w.tex_u = $urandom; w.tex_v = $urandom;
    end else begin
      w.pos_x = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      w.pos_y = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      w.pos_z = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      w.tex_u = 16'($urandom_range(0, 16'h4000));
      w.tex_v = 16'($urandom_range(0, 16'h4000));
    end
    return w;
  endfunction

  initial begin
    int burst_left;
    in_word_t w;
    in_valid = 1'b0;
    in_word  = '0;
    corners_sent = 0;
    burst_left = 4;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unit right triangle, plain tangent along x
    send_corner(corner(32'd0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    send_corner(corner(32'd1, 32'h0001_0000, 32'h0, 32'h0, 16'h4000, 16'h0));
    send_corner(corner(32'd2, 32'h0, 32'h0001_0000, 32'h0, 16'h0, 16'h4000));
    // degenerate: all uvs equal
    send_corner(corner(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 16'h7FFF, 16'h8000));
    send_corner(corner(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h7FFF, 16'h8000));
    send_corner(corner(32'h0, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000));
    // huge edges over a tiny determinant: positive and negative saturation
    send_corner(corner(32'd10, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h0));
    send_corner(corner(32'd11, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h1, 16'h0));
    send_corner(corner(32'd12, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h1));
    // extreme uvs in both directions, negative determinant
    send_corner(corner(32'd20, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h7FFF));
    send_corner(corner(32'd21, 32'hFFFF_0000, 32'h0003_0000, 32'h0, 16'h7FFF, 16'h7FFF));
    send_corner(corner(32'd22, 32'h0, 32'h0, 32'h0005_0000, 16'h7FFF, 16'h8000));
    // collinear uvs
    send_corner(corner(32'd30, 32'h1, 32'h2, 32'h3, 16'h0100, 16'h0100));
    send_corner(corner(32'd31, 32'h4, 32'h5, 32'h6, 16'h0200, 16'h0200));
    send_corner(corner(32'd32, 32'h7, 32'h8, 32'h9, 16'h0400, 16'h0400));

    // hold off until every pending tangent has come out
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    for (int i = 0; i < 32; i++) begin
      for (int c = 0; c < 3; c++) begin
        w = rand_corner();
        // occasionally repeat a uv so some triangles collapse
        if (c > 0 && $urandom_range(0, 9) == 0) begin
          w.tex_u = in_word.tex_u; w.tex_v = in_word.tex_v;
        end
        send_corner(w);
        gap_after_burst(burst_left);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("sent %0d corners, checked %0d tangent words", corners_sent, results);
    $display("zero-determinant triangles %0d, saturated components %0d", degen_cnt, sat_cnt);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
